// ===== rtl/bst_pkg.sv =====
// Shared constants, codes and controller/datapath signal groups of the bounded set table.
package bst_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned KEY_IN_W    = 32;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned COUNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic search;
    logic append;
    logic rm_read;
    logic rm_write;
    logic publish;
    logic ok;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic hit;
    logic issue_done;
    logic full;
  } sts_t;

endpackage

// ===== rtl/bst_req_if.sv =====
// Request channel: operation and key with valid/ready handshake.
interface bst_req_if;
  logic                            valid;
  logic                            ready;
  logic [bst_pkg::OP_W-1:0]        op;
  logic [bst_pkg::KEY_IN_W-1:0]    key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

// ===== rtl/bst_rsp_if.sv =====
// Response channel: success flag and live count with valid/ready handshake.
interface bst_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic [bst_pkg::COUNT_OUT_W-1:0]   count;

  modport source (output valid, output ok, output count, input ready);
  modport sink   (input valid, input ok, input count, output ready);
endinterface

// ===== rtl/bst_datapath.sv =====
// Datapath: key table memory, live count, search index, compare and result register.
module bst_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [bst_pkg::OP_W-1:0]          op_i,
  input  logic [bst_pkg::KEY_IN_W-1:0]      key_i,
  input  bst_pkg::cmd_t                     cmd_i,
  output bst_pkg::sts_t                     sts_o,
  output logic                              out_ok_o,
  output logic [bst_pkg::COUNT_OUT_W-1:0]   out_count_o
);

  logic [bst_pkg::KEY_WIDTH-1:0] mem [bst_pkg::CAPACITY];

  bst_pkg::op_e                  op_q;
  logic [bst_pkg::KEY_WIDTH-1:0] key_q;
  logic [bst_pkg::KEY_WIDTH-1:0] rd_q;
  logic [bst_pkg::COUNT_W-1:0]   count_q, count_d;
  logic [bst_pkg::COUNT_W-1:0]   idx_q;
  logic [bst_pkg::COUNT_W-1:0]   last_idx;
  logic [bst_pkg::IDX_W-1:0]     rd_idx_q;
  logic [bst_pkg::IDX_W-1:0]     slot_q;
  logic                          rd_vld_q;
  logic                          out_ok_q;
  logic [bst_pkg::COUNT_OUT_W-1:0] out_count_q;

  logic                          hit;
  logic                          issue;
  logic [bst_pkg::IDX_W-1:0]     raddr;
  logic [bst_pkg::IDX_W-1:0]     waddr;
  logic [bst_pkg::KEY_WIDTH-1:0] wdata;
  logic                          we;

  assign hit      = rd_vld_q && (rd_q == key_q);
  assign issue    = cmd_i.search && (idx_q != count_q);
  assign last_idx = count_q - bst_pkg::COUNT_W'(1);
  assign raddr    = cmd_i.rm_read ? last_idx[bst_pkg::IDX_W-1:0] : idx_q[bst_pkg::IDX_W-1:0];
  assign waddr    = cmd_i.rm_write ? slot_q : count_q[bst_pkg::IDX_W-1:0];
  assign wdata    = cmd_i.rm_write ? rd_q : key_q;
  assign we       = cmd_i.append || cmd_i.rm_write;

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.append) begin
      count_d = count_q + bst_pkg::COUNT_W'(1);
    end else if (cmd_i.rm_write) begin
      count_d = last_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue || cmd_i.rm_read) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_vld_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
      end else begin
        rd_vld_q <= issue;
        if (issue) begin
          idx_q <= idx_q + bst_pkg::COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= bst_pkg::op_e'(op_i);
      key_q <= bst_pkg::KEY_WIDTH'(key_i);
    end
    if (issue) begin
      rd_idx_q <= idx_q[bst_pkg::IDX_W-1:0];
    end
    if (hit) begin
      slot_q <= rd_idx_q;
    end
    if (cmd_i.publish) begin
      out_ok_q    <= cmd_i.ok;
      out_count_q <= bst_pkg::COUNT_OUT_W'(count_q);
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.hit        = hit;
  assign sts_o.issue_done = (idx_q == count_q);
  assign sts_o.full       = (count_q == bst_pkg::COUNT_W'(bst_pkg::CAPACITY));
  assign out_ok_o         = out_ok_q;
  assign out_count_o      = out_count_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bst_pkg::COUNT_W'(bst_pkg::CAPACITY))
    else $error("live count exceeds capacity");

  a_append_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !sts_o.full)
    else $error("append into a full table");

  a_remove_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rm_write |-> count_q != '0)
    else $error("remove from an empty table");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> count_q == '0)
    else $error("clear left entries live");

endmodule

// ===== rtl/bst_ctrl.sv =====
// Controller: sequences accept, linear search, update and result transfer.
module bst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bst_pkg::sts_t sts_i,
  output bst_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_REM_RD,
    S_REM_WR,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   ok_q, ok_d;
  logic   out_vld_q, out_vld_d;
  bst_pkg::cmd_t cmd;

  always_comb begin
    state_d = state_q;
    ok_d    = ok_q;
    cmd     = '0;
    cmd.ok  = ok_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op == bst_pkg::OP_CLEAR) begin
          cmd.clear = 1'b1;
          ok_d      = 1'b1;
          state_d   = S_FINISH;
        end else if (sts_i.op == bst_pkg::OP_ADD && sts_i.full) begin
          ok_d    = 1'b0;
          state_d = S_FINISH;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (sts_i.hit) begin
          case (sts_i.op)
            bst_pkg::OP_REMOVE: begin
              state_d = S_REM_RD;
            end
            bst_pkg::OP_CONTAINS: begin
              ok_d    = 1'b1;
              state_d = S_FINISH;
            end
            default: begin
              ok_d    = 1'b0;
              state_d = S_FINISH;
            end
          endcase
        end else if (sts_i.issue_done) begin
          if (sts_i.op == bst_pkg::OP_ADD) begin
            cmd.append = 1'b1;
            ok_d       = 1'b1;
          end else begin
            ok_d = 1'b0;
          end
          state_d = S_FINISH;
        end
      end
      S_REM_RD: begin
        cmd.rm_read = 1'b1;
        state_d     = S_REM_WR;
      end
      S_REM_WR: begin
        cmd.rm_write = 1'b1;
        ok_d         = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (!out_vld_q || out_ready_i) begin
          cmd.publish = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_vld_d = (out_vld_q && !out_ready_i) || cmd.publish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ok_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ok_q      <= ok_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign cmd_o       = cmd;

  a_publish_raises_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |=> out_vld_q)
    else $error("result register not loaded on publish");

  a_remove_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REM_RD |=> state_q == S_REM_WR)
    else $error("remove did not move the last entry");

  a_search_ends_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && sts_i.hit) |=> state_q != S_SEARCH)
    else $error("search continued after a match");

endmodule

// ===== rtl/bounded_set_table_core.sv =====
// Top level of the bounded set table: controller, datapath and channel wiring.
// A set of up to CAPACITY keys held unordered in a single-port table memory with a live count.
// One request is in flight at a time. Add, remove and contains walk the live entries with one
// memory read per cycle until a match or the end of the live entries; a matching remove then
// fetches the last entry and moves it into the freed slot, and clear or add to a full table
// skip the search. The next request can be taken in the cycle after the result is loaded.
// The result sits in its own register, so the next request is taken while an earlier result
// still waits for transfer; a finished request holds its result until that earlier result is
// transferred. No clearing pass follows reset.
module bounded_set_table_core (
  input logic      clk_i,
  input logic      rst_ni,
  bst_req_if.sink  req_i,
  bst_rsp_if.source rsp_o
);

  bst_pkg::cmd_t cmd;
  bst_pkg::sts_t sts;

  bst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (req_i.op),
    .key_i       (req_i.key),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ok_o    (rsp_o.ok),
    .out_count_o (rsp_o.count)
  );

endmodule
